/* src/counted_binary_trie_xor_query_defines.svh */
// Assertion macros for the counted binary trie XOR query block.
`ifndef COUNTED_BINARY_TRIE_XOR_QUERY_DEFINES_SVH
`define COUNTED_BINARY_TRIE_XOR_QUERY_DEFINES_SVH
`ifndef ASSERT_OFF
`define CBT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CBT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `CBT_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define CBT_ASSERT(lbl, clk, rst_n, prop, msg)
`define CBT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

/* src/cbt_pkg.sv */
// Package with sizes, codes and types shared by the trie query block.
`timescale 1ns / 1ps
package cbt_pkg;

    localparam int KEY_BITS   = 30;
    localparam int NODE_COUNT = 262144;
    localparam int COUNT_BITS = 20;

    localparam int NODE_BITS = $clog2(NODE_COUNT);
    localparam int LVL_BITS  = $clog2(KEY_BITS);
    localparam int NEED_BITS = $clog2(KEY_BITS + 1);
    localparam int ALU_W     = (COUNT_BITS > NODE_BITS + 1) ? COUNT_BITS : NODE_BITS + 1;
    localparam int NODE_LAST = NODE_COUNT - 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam int IN_DATA_BITS  = ((2 * KEY_BITS + 7) / 8) * 8;
    localparam int MODE_BITS     = 2;
    localparam int STATUS_BITS   = 2;
    localparam int OUT_DATA_BITS = ((1 + STATUS_BITS + 7) / 8) * 8;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_WALK,
        S_ROOM,
        S_UPD,
        S_NEW,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_ROOM
    } t_alu_op;

    typedef logic [1:0][NODE_BITS-1:0] t_links;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        t_links                links;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

    typedef struct packed {
        t_alu_op          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             flag;
    } t_alu_rsp;

    typedef struct packed {
        t_mode               mode;
        logic [KEY_BITS-1:0] key;
        logic [KEY_BITS-1:0] threshold;
    } t_req;

    typedef struct packed {
        logic    found;
        t_status status;
    } t_rsp;

    typedef struct packed {
        logic start;
        t_req req;
        logic ack;
    } t_ctl_in;

    typedef struct packed {
        logic ready;
        logic done;
        t_rsp rsp;
    } t_ctl_out;

endpackage

/* src/counted_binary_trie_xor_query.sv */
// Top level of the counted binary trie store with max-XOR threshold query.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tdata key, threshold; tuser mode
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata found, status
//
// Each insert, delete or query walks the trie one level per cycle with one registered RAM read per level.
// Query makes a single pass; insert and delete make a check pass, then an update pass,
// and a failed check ends after the check pass. Clear does no walk.
// Reset clears root links and the allocation count; no clearing pass over the RAM.
// Input is held off until the result is loaded; the next beat is taken in the cycle after that.
// A finished result stalls only while the output register holds an unaccepted beat.
`timescale 1ns / 1ps
`include "counted_binary_trie_xor_query_defines.svh"
module counted_binary_trie_xor_query (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // key[29:0], threshold[59:30], zero pad
    input  logic [cbt_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    // mode[1:0]
    input  logic [cbt_pkg::MODE_BITS-1:0]     s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // found[0], status[2:1], zero pad
    output logic [cbt_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);
    import cbt_pkg::*;

    t_ctl_in  w_ctl;
    t_ctl_out w_stat;
    logic     w_load;
    logic     r_out_valid, n_out_valid;
    t_rsp     r_out_rsp;

    cbt_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_stat  (w_stat)
    );

    assign s_axis_tready       = w_stat.ready;
    assign w_ctl.start         = s_axis_tvalid && s_axis_tready;
    assign w_ctl.req.mode      = t_mode'(s_axis_tuser);
    assign w_ctl.req.key       = s_axis_tdata[KEY_BITS-1:0];
    assign w_ctl.req.threshold = s_axis_tdata[2*KEY_BITS-1:KEY_BITS];
    assign w_load              = w_stat.done && (!r_out_valid || m_axis_tready);
    assign w_ctl.ack           = w_load;

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_rsp <= w_stat.rsp;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_BITS'({r_out_rsp.status, r_out_rsp.found});

    `CBT_ASSERT(a_load_from_done, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(w_stat.done), "result beat without a finished operation")
    `CBT_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "input taken while an operation runs")
    `CBT_ASSERT_NEVER(a_found_status_ok, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[0] && (m_axis_tdata[2:1] != ST_OK), "found set with error status")

endmodule

/* src/cbt_ram.sv */
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
module cbt_ram #(
    parameter int DEPTH  = 2,
    parameter int WIDTH  = 1,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr_a,
    input  logic [ADDR_W-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]  o_rd_data_a,
    output logic [WIDTH-1:0]  o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

/* src/cbt_alu.sv */
// Shared adder and compare unit for node counts and node allocation.
`timescale 1ns / 1ps
module cbt_alu (
    input  cbt_pkg::t_alu_req i_req,
    output cbt_pkg::t_alu_rsp o_rsp
);
    import cbt_pkg::*;

    logic [ALU_W-1:0] w_sum;

    always_comb begin
        case (i_req.op)
            ALU_SUB: begin
                w_sum = i_req.a - i_req.b;
            end
            default: begin
                w_sum = i_req.a + i_req.b;
            end
        endcase
    end

    assign o_rsp.sum  = w_sum;
    assign o_rsp.flag = (i_req.op == ALU_ROOM) ? (w_sum > ALU_W'(NODE_LAST))
                                               : (i_req.a == ALU_W'(COUNT_MAX));

endmodule

/* src/cbt_seq.sv */
// Sequencer that walks the trie one level per cycle over the node store.
`timescale 1ns / 1ps
module cbt_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cbt_pkg::t_ctl_in  i_ctl,
    output cbt_pkg::t_ctl_out o_stat
);
    import cbt_pkg::*;

    t_state                r_state, n_state;
    logic [LVL_BITS-1:0]   r_lv, n_lv;
    logic [NEED_BITS-1:0]  r_need, n_need;
    logic                  r_upd, n_upd;
    t_mode                 r_mode, n_mode;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [KEY_BITS-1:0]   r_thr, n_thr;
    t_links                r_root, n_root;
    logic [NODE_BITS-1:0]  r_last, n_last;
    logic [NODE_BITS-1:0]  r_addr_a, r_addr_b;
    logic                  r_found, n_found;
    t_status               r_status, n_status;

    t_entry                w_rd_a, w_rd_b, w_wr_entry;
    logic                  w_wr_en;
    logic [NODE_BITS-1:0]  w_wr_addr;
    logic [NODE_BITS-1:0]  w_rd_addr_a, w_rd_addr_b;
    t_alu_req              w_alu_req;
    t_alu_rsp              w_alu_rsp;

    logic                  w_kb, w_tb, w_kb_dn, w_top, w_bottom;
    logic [LVL_BITS-1:0]   w_lv_dn;
    logic [COUNT_BITS-1:0] w_cnt_a, w_cnt_b;
    logic                  w_a_live, w_b_live;
    logic                  w_q_empty, w_q_stop, w_q_found, w_sel_b;
    logic [NODE_BITS-1:0]  w_next_idx, w_new_idx, w_new_idx2;
    t_links                w_next_links, w_src_links;
    logic                  w_src_bit, w_hook, w_full_need;
    logic [NEED_BITS-1:0]  w_need_lv;

    cbt_ram #(
        .DEPTH (NODE_COUNT),
        .WIDTH (ENTRY_BITS)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_wr_entry),
        .i_rd_addr_a (w_rd_addr_a),
        .i_rd_addr_b (w_rd_addr_b),
        .o_rd_data_a (w_rd_a),
        .o_rd_data_b (w_rd_b)
    );

    cbt_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    assign w_kb     = r_key[r_lv];
    assign w_tb     = r_thr[r_lv];
    assign w_lv_dn  = r_lv - LVL_BITS'(1);
    assign w_kb_dn  = r_key[w_lv_dn];
    assign w_top    = (r_lv == LVL_BITS'(KEY_BITS - 1));
    assign w_bottom = (r_lv == '0);

    assign w_cnt_a  = (r_addr_a == '0) ? '0 : w_rd_a.count;
    assign w_cnt_b  = (r_addr_b == '0) ? '0 : w_rd_b.count;
    assign w_a_live = (w_cnt_a != '0);
    assign w_b_live = (w_cnt_b != '0);

    assign w_q_empty = w_top && !w_a_live && !w_b_live;
    assign w_q_stop  = w_q_empty || (w_b_live != w_tb) || w_bottom;
    assign w_q_found = !w_q_empty && (w_b_live || !w_tb);
    assign w_sel_b   = (r_mode == MODE_QUERY) && w_b_live;

    assign w_next_idx   = w_sel_b ? r_addr_b : r_addr_a;
    assign w_next_links = (w_next_idx == '0) ? r_root
                                             : (w_sel_b ? w_rd_b.links : w_rd_a.links);
    assign w_src_links  = (r_state == S_ISSUE) ? r_root : w_next_links;
    assign w_src_bit    = (r_state == S_ISSUE) ? w_kb : w_kb_dn;
    assign w_rd_addr_a  = w_src_links[w_src_bit];
    assign w_rd_addr_b  = w_src_links[~w_src_bit];

    assign w_new_idx   = r_last + NODE_BITS'(1);
    assign w_new_idx2  = r_last + NODE_BITS'(2);
    assign w_need_lv   = NEED_BITS'(r_lv) + NEED_BITS'(1);
    assign w_full_need = (r_need == NEED_BITS'(KEY_BITS));
    assign w_hook      = (r_mode == MODE_INSERT) && (r_need != '0)
                         && (NEED_BITS'(r_lv) == r_need);

    always_comb begin
        w_alu_req.op = ALU_ADD;
        w_alu_req.a  = ALU_W'(w_rd_a.count);
        w_alu_req.b  = ALU_W'(1);
        case (r_state)
            S_ROOM: begin
                w_alu_req.op = ALU_ROOM;
                w_alu_req.a  = ALU_W'(r_last);
                w_alu_req.b  = ALU_W'(r_need);
            end
            S_UPD: begin
                if (r_mode == MODE_DELETE) begin
                    w_alu_req.op = ALU_SUB;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_state = (i_ctl.req.mode == MODE_CLEAR) ? S_DONE : S_ISSUE;
                end
            end
            S_ISSUE: begin
                n_state = r_upd ? S_UPD : S_WALK;
            end
            S_WALK: begin
                case (r_mode)
                    MODE_INSERT: begin
                        if (r_addr_a == '0) begin
                            n_state = S_ROOM;
                        end else if (w_alu_rsp.flag) begin
                            n_state = S_DONE;
                        end else if (w_bottom) begin
                            n_state = S_ROOM;
                        end
                    end
                    MODE_DELETE: begin
                        if (!w_a_live) begin
                            n_state = S_DONE;
                        end else if (w_bottom) begin
                            n_state = S_ISSUE;
                        end
                    end
                    MODE_QUERY: begin
                        if (w_q_stop) begin
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_ROOM: begin
                if (w_alu_rsp.flag) begin
                    n_state = S_DONE;
                end else if (w_full_need) begin
                    n_state = S_NEW;
                end else begin
                    n_state = S_ISSUE;
                end
            end
            S_UPD: begin
                if (w_hook) begin
                    n_state = S_NEW;
                end else if (w_bottom) begin
                    n_state = S_DONE;
                end
            end
            S_NEW: begin
                if (w_bottom) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_ctl.ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_lv       = r_lv;
        n_need     = r_need;
        n_upd      = r_upd;
        n_mode     = r_mode;
        n_key      = r_key;
        n_thr      = r_thr;
        n_root     = r_root;
        n_last     = r_last;
        n_found    = r_found;
        n_status   = r_status;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_addr_a;
        w_wr_entry = w_rd_a;
        case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_mode   = i_ctl.req.mode;
                    n_key    = i_ctl.req.key;
                    n_thr    = i_ctl.req.threshold;
                    n_found  = 1'b0;
                    n_status = ST_OK;
                    n_lv     = LVL_BITS'(KEY_BITS - 1);
                    n_upd    = 1'b0;
                    if (i_ctl.req.mode == MODE_CLEAR) begin
                        n_root = '0;
                        n_last = '0;
                    end
                end
            end
            S_WALK: begin
                n_lv = w_lv_dn;
                case (r_mode)
                    MODE_INSERT: begin
                        if (r_addr_a == '0) begin
                            n_need = w_need_lv;
                        end else if (w_alu_rsp.flag) begin
                            n_status = ST_FULL;
                        end else if (w_bottom) begin
                            n_need = '0;
                        end
                    end
                    MODE_DELETE: begin
                        if (!w_a_live) begin
                            n_status = ST_ABSENT;
                        end else if (w_bottom) begin
                            n_upd = 1'b1;
                            n_lv  = LVL_BITS'(KEY_BITS - 1);
                        end
                    end
                    MODE_QUERY: begin
                        n_found = w_q_found;
                    end
                    default: begin
                    end
                endcase
            end
            S_ROOM: begin
                n_upd = 1'b1;
                n_lv  = LVL_BITS'(KEY_BITS - 1);
                if (w_alu_rsp.flag) begin
                    n_status = ST_FULL;
                end else if (w_full_need) begin
                    n_root[r_key[KEY_BITS-1]] = w_new_idx;
                end
            end
            S_UPD: begin
                w_wr_en          = 1'b1;
                w_wr_addr        = r_addr_a;
                w_wr_entry.count = COUNT_BITS'(w_alu_rsp.sum);
                w_wr_entry.links = w_rd_a.links;
                if (w_hook) begin
                    w_wr_entry.links[w_kb_dn] = w_new_idx;
                end
                n_lv = w_lv_dn;
            end
            S_NEW: begin
                w_wr_en          = 1'b1;
                w_wr_addr        = w_new_idx;
                w_wr_entry.count = COUNT_BITS'(1);
                w_wr_entry.links = '0;
                if (!w_bottom) begin
                    w_wr_entry.links[w_kb_dn] = w_new_idx2;
                end
                n_last = w_new_idx;
                n_lv   = w_lv_dn;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.ready      = (r_state == S_IDLE);
    assign o_stat.done       = (r_state == S_DONE);
    assign o_stat.rsp.found  = r_found;
    assign o_stat.rsp.status = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lv    <= '0;
            r_need  <= '0;
            r_upd   <= 1'b0;
            r_root  <= '0;
            r_last  <= '0;
        end else begin
            r_state <= n_state;
            r_lv    <= n_lv;
            r_need  <= n_need;
            r_upd   <= n_upd;
            r_root  <= n_root;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_key    <= n_key;
        r_thr    <= n_thr;
        r_found  <= n_found;
        r_status <= n_status;
        r_addr_a <= w_rd_addr_a;
        r_addr_b <= w_rd_addr_b;
    end

endmodule

/* tb/counted_binary_trie_xor_query_tb.sv */
// Self-checking bench for the counted binary trie store with max-XOR threshold query.
`timescale 1ns / 1ps
module counted_binary_trie_xor_query_tb;
    import cbt_pkg::*;

    localparam bit [KEY_BITS-1:0] KEY_MAX  = '1;
    localparam int                RANDOM_N = 1250;
    localparam int                POOL_N   = 16;

    typedef struct packed {
        bit      typed;
        bit      found;
        t_status status;
    } t_typed;

    typedef struct {
        t_mode               mode;
        bit [KEY_BITS-1:0]   key;
        bit [KEY_BITS-1:0]   thr;
        bit                  typed;
        bit                  found;
        t_status             status;
    } t_row;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
    logic [MODE_BITS-1:0]     s_axis_tuser  = MODE_INSERT;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;

    bit [NODE_BITS-1:0]  node_link [NODE_COUNT][2];
    bit [COUNT_BITS-1:0] node_cnt  [NODE_COUNT];
    bit [NODE_BITS-1:0]  root_link [2];
    int unsigned         node_top;

    t_rsp   answer_q[$];
    t_typed typed_answer_q[$];
    bit [KEY_BITS-1:0] key_pool [POOL_N];

    int mismatches   = 0;
    int burst_left   = 0;
    int rx_left      = 0;

    t_row plan [0:24] = '{
        '{MODE_QUERY,  30'h0,        30'h0,        1'b1, 1'b0, ST_OK},
        '{MODE_DELETE, 30'h0,        KEY_MAX,      1'b1, 1'b0, ST_ABSENT},
        '{MODE_CLEAR,  30'h0,        30'h0,        1'b1, 1'b0, ST_OK},
        '{MODE_INSERT, 30'h0,        KEY_MAX,      1'b1, 1'b0, ST_OK},
        '{MODE_QUERY,  30'h0,        30'h0,        1'b1, 1'b1, ST_OK},
        '{MODE_QUERY,  30'h0,        30'h1,        1'b1, 1'b0, ST_OK},
        '{MODE_INSERT, KEY_MAX,      30'h0,        1'b1, 1'b0, ST_OK},
        '{MODE_QUERY,  30'h0,        KEY_MAX,      1'b1, 1'b1, ST_OK},
        '{MODE_QUERY,  KEY_MAX,      KEY_MAX,      1'b0, 1'b0, ST_OK},
        '{MODE_QUERY,  30'h15555555, KEY_MAX,      1'b0, 1'b0, ST_OK},
        '{MODE_QUERY,  30'h2AAAAAAA, 30'h2AAAAAAA, 1'b0, 1'b0, ST_OK},
        '{MODE_DELETE, 30'h0,        30'h0,        1'b0, 1'b0, ST_OK},
        '{MODE_DELETE, 30'h0,        30'h0,        1'b1, 1'b0, ST_ABSENT},
        '{MODE_QUERY,  KEY_MAX,      30'h1,        1'b0, 1'b0, ST_OK},
        '{MODE_INSERT, 30'h0,        30'h15555555, 1'b0, 1'b0, ST_OK},
        '{MODE_INSERT, 30'h0,        30'h0,        1'b0, 1'b0, ST_OK},
        '{MODE_DELETE, 30'h0,        30'h2AAAAAAA, 1'b0, 1'b0, ST_OK},
        '{MODE_QUERY,  30'h0,        30'h0,        1'b0, 1'b0, ST_OK},
        '{MODE_DELETE, 30'h1,        30'h0,        1'b1, 1'b0, ST_ABSENT},
        '{MODE_INSERT, 30'h1,        30'h0,        1'b0, 1'b0, ST_OK},
        '{MODE_QUERY,  30'h1,        KEY_MAX,      1'b0, 1'b0, ST_OK},
        '{MODE_QUERY,  30'h1,        30'h3FFFFFFE, 1'b0, 1'b0, ST_OK},
        '{MODE_CLEAR,  30'h0,        KEY_MAX,      1'b0, 1'b0, ST_OK},
        '{MODE_QUERY,  30'h0,        30'h0,        1'b1, 1'b0, ST_OK},
        '{MODE_DELETE, KEY_MAX,      30'h0,        1'b1, 1'b0, ST_ABSENT}
    };

    counted_binary_trie_xor_query u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned trie_child(int unsigned node, bit b);
        if (node == 0)
            return root_link[b];
        return node_link[node][b];
    endfunction

    function automatic int unsigned trie_count(int unsigned node);
        if (node == 0)
            return 0;
        return node_cnt[node];
    endfunction

    function automatic t_status trie_insert(bit [KEY_BITS-1:0] key);
        int unsigned cur;
        int unsigned nxt;
        int unsigned need;
        int          lvl;
        cur  = 0;
        need = 0;
        lvl  = KEY_BITS - 1;
        while (lvl >= 0 && need == 0) begin
            nxt = trie_child(cur, key[lvl]);
            if (nxt == 0) begin
                need = lvl + 1;
            end else begin
                if (node_cnt[nxt] == COUNT_MAX)
                    return ST_FULL;
                cur = nxt;
            end
            lvl--;
        end
        if (node_top + need > NODE_COUNT - 1)
            return ST_FULL;
        cur = 0;
        for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
            nxt = trie_child(cur, key[lvl]);
            if (nxt == 0) begin
                node_top++;
                nxt = node_top;
                node_link[nxt][0] = '0;
                node_link[nxt][1] = '0;
                node_cnt[nxt]     = '0;
                if (cur == 0)
                    root_link[key[lvl]] = NODE_BITS'(nxt);
                else
                    node_link[cur][key[lvl]] = NODE_BITS'(nxt);
            end
            node_cnt[nxt]++;
            cur = nxt;
        end
        return ST_OK;
    endfunction

    function automatic t_status trie_delete(bit [KEY_BITS-1:0] key);
        int unsigned cur;
        int unsigned nxt;
        int          lvl;
        cur = 0;
        for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
            nxt = trie_child(cur, key[lvl]);
            if (trie_count(nxt) == 0)
                return ST_ABSENT;
            cur = nxt;
        end
        cur = 0;
        for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
            nxt = trie_child(cur, key[lvl]);
            node_cnt[nxt]--;
            cur = nxt;
        end
        return ST_OK;
    endfunction

    function automatic bit trie_query(bit [KEY_BITS-1:0] key, bit [KEY_BITS-1:0] thr);
        int unsigned cur;
        int unsigned other;
        int          lvl;
        if (trie_count(root_link[0]) == 0 && trie_count(root_link[1]) == 0)
            return 1'b0;
        cur = 0;
        for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
            other = trie_child(cur, !key[lvl]);
            if (trie_count(other) == 0) begin
                if (thr[lvl])
                    return 1'b0;
                cur = trie_child(cur, key[lvl]);
            end else begin
                if (!thr[lvl])
                    return 1'b1;
                cur = other;
            end
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : accept_mon
        t_mode             mode;
        bit [KEY_BITS-1:0] key;
        bit [KEY_BITS-1:0] thr;
        t_rsp              want;
        t_typed            typed;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            mode        = t_mode'(s_axis_tuser);
            key         = s_axis_tdata[KEY_BITS-1:0];
            thr         = s_axis_tdata[2*KEY_BITS-1:KEY_BITS];
            want.found  = 1'b0;
            want.status = ST_OK;
            case (mode)
                MODE_INSERT: want.status = trie_insert(key);
                MODE_DELETE: want.status = trie_delete(key);
                MODE_QUERY:  want.found  = trie_query(key, thr);
                default: begin
                    root_link[0] = '0;
                    root_link[1] = '0;
                    node_top     = 0;
                end
            endcase
            if (typed_answer_q.size() != 0) begin
                typed = typed_answer_q.pop_front();
                if (typed.typed) begin
                    want.found  = typed.found;
                    want.status = typed.status;
                end
            end
            answer_q = {answer_q, want};
        end
    end

    always @(posedge i_clk) begin : result_mon
        t_rsp want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (answer_q.size() == 0) begin
                $error("unexpected result beat: tdata %0h", m_axis_tdata);
                mismatches++;
            end else begin
                want = answer_q.pop_front();
                if (m_axis_tdata[0] !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, m_axis_tdata[0]);
                    mismatches++;
                end
                if (m_axis_tdata[2:1] !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status,
                           m_axis_tdata[2:1]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            if ($urandom_range(0, 9) < 6) begin
                m_axis_tready <= 1'b1;
                rx_left = $urandom_range(1, 40);
            end else begin
                m_axis_tready <= 1'b0;
                rx_left = $urandom_range(1, 12);
            end
        end else begin
            rx_left--;
        end
    end

    task automatic put_beat(t_mode mode, bit [KEY_BITS-1:0] key, bit [KEY_BITS-1:0] thr,
                            bit typed, bit found, t_status status);
        int gap;
        typed_answer_q = {typed_answer_q, t_typed'{typed, found, status}};
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= IN_DATA_BITS'({thr, key});
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 90) : $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    function automatic bit [KEY_BITS-1:0] fresh_key();
        if ($urandom_range(0, 2) == 0)
            return key_pool[$urandom_range(0, POOL_N - 1)] ^ (KEY_BITS'(1) << $urandom_range(0, 29));
        return KEY_BITS'($urandom);
    endfunction

    function automatic bit [KEY_BITS-1:0] pick_threshold(bit [KEY_BITS-1:0] key);
        bit [KEY_BITS-1:0] best;
        best = key ^ key_pool[$urandom_range(0, POOL_N - 1)];
        case ($urandom_range(0, 6))
            0: return KEY_BITS'($urandom);
            1: return best;
            2: return best + 1'b1;
            3: return best ^ (KEY_BITS'(1) << $urandom_range(0, 29));
            4: return '0;
            5: return KEY_MAX;
            default: return KEY_BITS'($urandom) >> $urandom_range(0, 29);
        endcase
    endfunction

    task automatic random_item();
        int unsigned       pick;
        int unsigned       slot;
        bit [KEY_BITS-1:0] key;
        pick = $urandom_range(0, 99);
        slot = $urandom_range(0, POOL_N - 1);
        key  = ($urandom_range(0, 3) == 0) ? fresh_key() : key_pool[slot];
        if (pick < 3) begin
            put_beat(MODE_CLEAR, KEY_BITS'($urandom), KEY_BITS'($urandom), 1'b0, 1'b0, ST_OK);
        end else if (pick < 33) begin
            if ($urandom_range(0, 4) == 0) begin
                key_pool[slot] = fresh_key();
                key            = key_pool[slot];
            end
            put_beat(MODE_INSERT, key, KEY_BITS'($urandom), 1'b0, 1'b0, ST_OK);
        end else if (pick < 55) begin
            put_beat(MODE_DELETE, key, KEY_BITS'($urandom), 1'b0, 1'b0, ST_OK);
        end else begin
            put_beat(MODE_QUERY, key, pick_threshold(key), 1'b0, 1'b0, ST_OK);
        end
    endtask

    initial begin
        int i;
        root_link[0] = '0;
        root_link[1] = '0;
        node_top     = 0;
        for (i = 0; i < POOL_N; i++)
            key_pool[i] = KEY_BITS'($urandom);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < 25; i++)
            put_beat(plan[i].mode, plan[i].key, plan[i].thr,
                     plan[i].typed, plan[i].found, plan[i].status);

        for (i = 0; i < RANDOM_N; i++)
            random_item();

        put_beat(MODE_CLEAR, '0, '0, 1'b0, 1'b0, ST_OK);
        for (i = 0; i < 8; i++)
            random_item();

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (answer_q.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (mismatches == 0)
            $display("counted_binary_trie_xor_query test passed");
        else
            $display("counted_binary_trie_xor_query test failed");
        $finish;
    end

    initial begin
        #80_000_000;
        $display("counted_binary_trie_xor_query test failed");
        $finish;
    end

endmodule

/* counted_binary_trie_xor_query.f */
+incdir+src
src/cbt_pkg.sv
src/cbt_ram.sv
src/cbt_alu.sv
src/cbt_seq.sv
src/counted_binary_trie_xor_query.sv
tb/counted_binary_trie_xor_query_tb.sv
